[hw/rtl/sfdp_pkg.sv]
// Shared constants and types for the starfield depth/projection block.
// No dependencies.
`timescale 1ns / 1ps

package sfdp_pkg;

  localparam int COORD_BITS_DEF      = 12;
  localparam int DEPTH_FRAC_BITS_DEF = 16;

  // velocity_step is Q0.24
  localparam int VEL_FRAC_BITS = 24;

  // quotient bits per divide; covers any screen extent (13-bit registers)
  localparam int QUOT_BITS = 13;

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  typedef enum logic [2:0] {
    REG_VELOCITY  = 3'd0,
    REG_MIN_STEP  = 3'd1,
    REG_SCREEN_W  = 3'd2,
    REG_SCREEN_H  = 3'd3,
    REG_GAIN      = 3'd4
  } reg_idx_t;

  localparam logic [15:0] VELOCITY_RST = 16'd5033;
  localparam logic [15:0] MIN_STEP_RST = 16'd66;
  localparam logic [12:0] SCREEN_W_RST = 13'd1280;
  localparam logic [12:0] SCREEN_H_RST = 13'd960;
  localparam logic [7:0]  GAIN_RST     = 8'd51;

endpackage

[hw/rtl/sfdp_ifs.sv]
// Valid/ready channel interfaces: star input and projected result.
// Depends on sfdp_pkg.
`timescale 1ns / 1ps

interface sfdp_star_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] star_x;
  logic signed [15:0] star_y;
  logic        [16:0] star_z;
  logic        [15:0] elapsed_ms;

  modport source (output valid, star_x, star_y, star_z, elapsed_ms, input ready);
  modport sink   (input valid, star_x, star_y, star_z, elapsed_ms, output ready);
endinterface

interface sfdp_result_if import sfdp_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [16:0]           new_z;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic                  on_screen;
  logic [7:0]            brightness;

  modport source (output valid, new_z, pixel_x, pixel_y, on_screen, brightness,
                  input ready);
  modport sink   (input valid, new_z, pixel_x, pixel_y, on_screen, brightness,
                  output ready);
endinterface

[hw/rtl/sfdp_div_pipe.sv]
// Pipelined restoring divider, one quotient bit per stage, with overflow flag
// and a sideband field carried alongside. Depends on sfdp_pkg.
`timescale 1ns / 1ps

module sfdp_div_pipe import sfdp_pkg::*; #(
  parameter int NUM_W  = 32,
  parameter int DEN_W  = 17,
  parameter int QW     = QUOT_BITS,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic [QW-1:0]     en,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic [QW-1:0]     quot,
  output logic              ovf,
  output logic [SIDE_W-1:0] side_out
);

  localparam int WW = ((NUM_W > DEN_W + QW) ? NUM_W : DEN_W + QW) + 1;

  logic [WW-1:0]     rem_r  [QW];
  logic [DEN_W-1:0]  den_r  [QW];
  logic [QW-1:0]     q_r    [QW];
  logic              ovf_r  [QW];
  logic [SIDE_W-1:0] side_r [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [WW-1:0]     rem_in;
    logic [DEN_W-1:0]  den_in;
    logic [QW-1:0]     q_in;
    logic              ovf_in;
    logic [SIDE_W-1:0] side_i;
    logic [WW-1:0]     trial;
    logic [WW-1:0]     rem_nx;
    logic [QW-1:0]     q_nx;

    if (i == 0) begin : g_first
      assign rem_in = WW'(num);
      assign den_in = den;
      assign q_in   = '0;
      assign ovf_in = WW'(num) >= (WW'(den) << QW);
      assign side_i = side_in;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign den_in = den_r[i-1];
      assign q_in   = q_r[i-1];
      assign ovf_in = ovf_r[i-1];
      assign side_i = side_r[i-1];
    end

    assign trial = WW'(den_in) << (QW - 1 - i);

    always_comb begin
      rem_nx = rem_in;
      q_nx   = q_in;
      if (rem_in >= trial) begin
        rem_nx = rem_in - trial;
        q_nx[QW-1-i] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en[i]) begin
        rem_r[i]  <= rem_nx;
        den_r[i]  <= den_in;
        q_r[i]    <= q_nx;
        ovf_r[i]  <= ovf_in;
        side_r[i] <= side_i;
      end
    end
  end

  assign quot     = q_r[QW-1];
  assign ovf      = ovf_r[QW-1];
  assign side_out = side_r[QW-1];

endmodule

[hw/rtl/starfield_depth_project_core.sv]
// Top level: starfield depth update, perspective projection and brightness.
// Depends on sfdp_pkg, sfdp_ifs (channel interfaces) and sfdp_div_pipe.
`timescale 1ns / 1ps

// Usage
//   star_in    : one star per transfer (x, y Q1.15; z Q0.F; elapsed ms).
//   result_out : one result per star, in order: wrapped depth, pixel column
//                and row, on-screen flag, brightness.
//   APB port   : five registers at byte offsets 0,4,8,12,16 (velocity step,
//                min step, view width, view height, brightness gain).
//                Write only while no star is in flight. pready is tied high.
// The input transfer reaches result valid through 18 register stages: four
// arithmetic stages (input multiplies, depth wrap, depth multiplies,
// numerator sums), 13 restoring-divide stages (one quotient bit each, three
// dividers side by side for column, row and brightness), and the output
// register.
// Throughput is one star per cycle unless the receiver stalls; every stage
// has its own valid bit and loads whenever it is empty or its successor
// moves, so bubbles collapse.
// When the receiver stalls, results stack up in the stage registers; input
// ready only drops once the pipeline is full back to the first stage.
// Reset (rst, synchronous) empties the pipeline and restores register
// defaults.
module starfield_depth_project_core import sfdp_pkg::*; #(
  parameter int COORD_BITS      = COORD_BITS_DEF,
  parameter int DEPTH_FRAC_BITS = DEPTH_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  sfdp_star_if.sink             star_in,
  sfdp_result_if.source         result_out,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int F   = DEPTH_FRAC_BITS;
  localparam int DW  = F + 1;          // depth 1..ONE
  localparam int NW  = F + 32;         // signed projection numerator
  localparam int PNW = NW - 17;        // numerator after dropping 2^16 and sign
  localparam int BNW = 8 + 2 * F;      // brightness numerator
  localparam int BDW = 2 * DW;         // depth squared
  localparam int QW  = QUOT_BITS;
  localparam int ZCW = (DW > 17) ? DW : 17;
  localparam logic [DW-1:0] ONE = {1'b1, {F{1'b0}}};

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [15:0] velocity_step;
  logic [15:0] min_step;
  logic [12:0] view_width;
  logic [12:0] view_height;
  logic [7:0]  brightness_gain;

  reg_idx_t reg_sel;
  logic     cfg_wr;

  assign reg_sel = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      velocity_step   <= VELOCITY_RST;
      min_step        <= MIN_STEP_RST;
      view_width      <= SCREEN_W_RST;
      view_height     <= SCREEN_H_RST;
      brightness_gain <= GAIN_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_VELOCITY: velocity_step   <= pwdata[15:0];
        REG_MIN_STEP: min_step        <= pwdata[15:0];
        REG_SCREEN_W: view_width      <= pwdata[12:0];
        REG_SCREEN_H: view_height     <= pwdata[12:0];
        REG_GAIN:     brightness_gain <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_VELOCITY: prdata = APB_DATA_W'(velocity_step);
      REG_MIN_STEP: prdata = APB_DATA_W'(min_step);
      REG_SCREEN_W: prdata = APB_DATA_W'(view_width);
      REG_SCREEN_H: prdata = APB_DATA_W'(view_height);
      REG_GAIN:     prdata = APB_DATA_W'(brightness_gain);
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Stage enables: a stage loads when empty or when its successor loads.
  // ---------------------------------------------------------------------
  logic          v1, v2, v3, v4, vo;
  logic [QW-1:0] vd;
  logic          en1, en2, en3, en4, en_o;
  logic [QW-1:0] en_d;

  assign en_o = !vo || result_out.ready;
  assign en_d[QW-1] = !vd[QW-1] || en_o;
  for (genvar i = 0; i < QW - 1; i++) begin : g_en
    assign en_d[i] = !vd[i] || en_d[i+1];
  end
  assign en4 = !v4 || en_d[0];
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;

  assign star_in.ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      vd <= '0;
      vo <= 1'b0;
    end else begin
      if (en1) v1 <= star_in.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en_d[0]) vd[0] <= v4;
      for (int i = 1; i < QW; i++) begin
        if (en_d[i]) vd[i] <= vd[i-1];
      end
      if (en_o) vo <= vd[QW-1];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: clamp input depth, velocity x ms, H x position
  // ---------------------------------------------------------------------
  logic [ZCW-1:0]     z_ext;
  logic [DW-1:0]      z_clamp;
  logic [31:0]        s1_prod;
  logic [DW-1:0]      s1_z;
  logic signed [29:0] s1_hx, s1_hy;

  assign z_ext = ZCW'(star_in.star_z);

  always_comb begin
    if (z_ext == '0) begin
      z_clamp = DW'(1);
    end else if (z_ext > ZCW'(ONE)) begin
      z_clamp = ONE;
    end else begin
      z_clamp = DW'(z_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_prod <= 32'(velocity_step) * 32'(star_in.elapsed_ms);
      s1_z    <= z_clamp;
      s1_hx   <= $signed({1'b0, view_height}) * star_in.star_x;
      s1_hy   <= $signed({1'b0, view_height}) * star_in.star_y;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: step saturation, minimum step, depth wrap into (0, ONE]
  // ---------------------------------------------------------------------
  logic [31:0]        step_raw;
  logic [DW-1:0]      step;
  logic signed [DW:0] dd;
  logic [DW-1:0]      s2_d;
  logic signed [29:0] s2_hx, s2_hy;

  assign step_raw = s1_prod >> (VEL_FRAC_BITS - F);

  always_comb begin
    if (step_raw > 32'(ONE)) begin
      step = ONE;
    end else if (step_raw == '0) begin
      step = (32'(min_step) > 32'(ONE)) ? ONE : DW'(min_step);
    end else begin
      step = DW'(step_raw);
    end
    dd = $signed({1'b0, s1_z}) - $signed({1'b0, step});
    if (dd <= 0) begin
      dd = dd + $signed({1'b0, ONE});
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_d  <= dd[DW-1:0];
      s2_hx <= s1_hx;
      s2_hy <= s1_hy;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: W*d, H*d (centre terms) and d^2
  // ---------------------------------------------------------------------
  logic [13+DW-1:0]   s3_wd, s3_hd;
  logic [BDW-1:0]     s3_dd;
  logic [DW-1:0]      s3_d;
  logic signed [29:0] s3_hx, s3_hy;

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_wd <= (13+DW)'(view_width) * (13+DW)'(s2_d);
      s3_hd <= (13+DW)'(view_height) * (13+DW)'(s2_d);
      s3_dd <= BDW'(s2_d) * BDW'(s2_d);
      s3_d  <= s2_d;
      s3_hx <= s2_hx;
      s3_hy <= s2_hy;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: numerators. col = floor((H*x*ONE + W*2^15*d) / (2^16*d));
  // the 2^16 is dropped from the numerator first (nested floor is exact).
  // A negative numerator means a negative coordinate: off screen.
  // ---------------------------------------------------------------------
  logic signed [NW-1:0] nx, ny;
  logic [PNW-1:0]       s4_nx, s4_ny;
  logic                 s4_negx, s4_negy;
  logic [BNW-1:0]       s4_bn;
  logic [BDW-1:0]       s4_bd;
  logic [DW-1:0]        s4_d;

  assign nx = ($signed(NW'(s3_hx)) <<< F) + $signed(NW'({s3_wd, 15'b0}));
  assign ny = ($signed(NW'(s3_hy)) <<< F) + $signed(NW'({s3_hd, 15'b0}));

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_nx   <= nx[NW-2:16];
      s4_ny   <= ny[NW-2:16];
      s4_negx <= nx[NW-1];
      s4_negy <= ny[NW-1];
      s4_bn   <= {brightness_gain, {(2*F){1'b0}}};
      s4_bd   <= s3_dd;
      s4_d    <= s3_d;
    end
  end

  // ---------------------------------------------------------------------
  // Divider pipelines (13 stages)
  // ---------------------------------------------------------------------
  logic [QW-1:0]   qx, qy, qb;
  logic            ovfx, ovfy, ovfb;
  logic [DW+1:0]   side_x;
  logic [DW-1:0]   dd_d;
  logic            negx_d, negy_d;

  sfdp_div_pipe #(
    .NUM_W(PNW), .DEN_W(DW), .QW(QW), .SIDE_W(DW + 2)
  ) u_div_x (
    .clk(clk), .en(en_d), .num(s4_nx), .den(s4_d),
    .side_in({s4_d, s4_negx, s4_negy}),
    .quot(qx), .ovf(ovfx), .side_out(side_x)
  );

  sfdp_div_pipe #(
    .NUM_W(PNW), .DEN_W(DW), .QW(QW), .SIDE_W(1)
  ) u_div_y (
    .clk(clk), .en(en_d), .num(s4_ny), .den(s4_d),
    .side_in(1'b0),
    .quot(qy), .ovf(ovfy), .side_out()
  );

  sfdp_div_pipe #(
    .NUM_W(BNW), .DEN_W(BDW), .QW(QW), .SIDE_W(1)
  ) u_div_b (
    .clk(clk), .en(en_d), .num(s4_bn), .den(s4_bd),
    .side_in(1'b0),
    .quot(qb), .ovf(ovfb), .side_out()
  );

  assign {dd_d, negx_d, negy_d} = side_x;

  // ---------------------------------------------------------------------
  // Output register: screen bounds, zeroing off screen, brightness clamp
  // ---------------------------------------------------------------------
  logic ok_x, ok_y, on_scr;

  assign ok_x = !negx_d && !ovfx && (qx < view_width) &&
                (17'(qx) < (17'(1) << COORD_BITS));
  assign ok_y = !negy_d && !ovfy && (qy < view_height) &&
                (17'(qy) < (17'(1) << COORD_BITS));
  assign on_scr = ok_x && ok_y;

  always_ff @(posedge clk) begin
    if (en_o) begin
      result_out.new_z      <= 17'(dd_d);
      result_out.pixel_x    <= on_scr ? COORD_BITS'(qx) : '0;
      result_out.pixel_y    <= on_scr ? COORD_BITS'(qy) : '0;
      result_out.on_screen  <= on_scr;
      result_out.brightness <= (ovfb || qb > QW'(255)) ? 8'd255 : qb[7:0];
    end
  end

  assign result_out.valid = vo;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_pix_inside: assert property (@(posedge clk) disable iff (rst)
    result_out.valid && result_out.on_screen |->
      (17'(result_out.pixel_x) < 17'(view_width)) &&
      (17'(result_out.pixel_y) < 17'(view_height)))
    else $error("on-screen pixel outside screen");

  a_pix_zero: assert property (@(posedge clk) disable iff (rst)
    result_out.valid && !result_out.on_screen |->
      result_out.pixel_x == '0 && result_out.pixel_y == '0)
    else $error("off-screen pixel not zeroed");

  a_depth_nz: assert property (@(posedge clk) disable iff (rst)
    v3 |-> s3_d != '0 && s3_d <= ONE)
    else $error("wrapped depth out of range");

  a_tail_hold: assert property (@(posedge clk) disable iff (rst)
    vd[QW-1] && !en_o |=> vd[QW-1])
    else $error("divider tail dropped a stalled item");

endmodule
